// File: src/rsamx_pkg.sv
// Shared constants for the RSA modular exponentiation block.
`timescale 1ns / 1ps
`default_nettype none
package rsamx_pkg;

   localparam int DATA_WIDTH_DEFAULT = 16;
   localparam int FIELD_WIDTH        = 16;
   localparam int CSR_ADDR_WIDTH     = 4;
   localparam int CSR_DATA_WIDTH     = 32;

   localparam logic [FIELD_WIDTH-1:0] RESET_MODULUS  = 16'd5141;
   localparam logic [FIELD_WIDTH-1:0] RESET_PUB_EXP  = 16'd7;
   localparam logic [FIELD_WIDTH-1:0] RESET_PRIV_EXP = 16'd4279;

   localparam logic [1:0] REG_MODULUS  = 2'd0;
   localparam logic [1:0] REG_PUB_EXP  = 2'd1;
   localparam logic [1:0] REG_PRIV_EXP = 2'd2;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

endpackage
`default_nettype wire

// File: src/rsamx_modmul.sv
// Bit-serial modular multiplier: one double-and-add step per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rsamx_modmul #(
   parameter int DATA_WIDTH = rsamx_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DATA_WIDTH-1:0] op_a,
   input  wire logic [DATA_WIDTH-1:0] op_b,
   input  wire logic [DATA_WIDTH-1:0] modulus,
   output logic                       done,
   output logic [DATA_WIDTH-1:0]      product
);

   logic                  run_ff, run_in;
   logic [DATA_WIDTH-1:0] a_ff, a_in;
   logic [DATA_WIDTH-1:0] b_ff, b_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;

   logic [DATA_WIDTH:0]   sum_acc, sum_dbl, mod_ext;
   logic [DATA_WIDTH-1:0] acc_step, a_step;

   // operands stay below the modulus, so one conditional subtract reduces each sum
   always_comb begin
      mod_ext  = {1'b0, modulus};
      sum_acc  = {1'b0, acc_ff} + {1'b0, a_ff};
      sum_dbl  = {1'b0, a_ff} + {1'b0, a_ff};
      acc_step = (sum_acc >= mod_ext) ? DATA_WIDTH'(sum_acc - mod_ext)
                                      : sum_acc[DATA_WIDTH-1:0];
      a_step   = (sum_dbl >= mod_ext) ? DATA_WIDTH'(sum_dbl - mod_ext)
                                      : sum_dbl[DATA_WIDTH-1:0];
   end

   always_comb begin
      run_in = run_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      acc_in = acc_ff;
      if (start) begin
         run_in = 1'b1;
         a_in   = op_a;
         b_in   = op_b;
         acc_in = '0;
      end else if (run_ff) begin
         if (b_ff == '0) begin
            run_in = 1'b0;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_step;
            end
            a_in = a_step;
            b_in = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = run_ff && (b_ff == '0);
   assign product = acc_ff;

endmodule
`default_nettype wire

// File: src/rsa_modular_exponentiation_top.sv
// Top level: register file, square-and-multiply sequencer and result register.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_cmd, req_value
//   rsp      out        rsp_valid/rsp_stall   rsp_result
//   csr      in         psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// One item at a time. The shared modular multiplier first reduces the base,
// then runs one square per significant exponent bit and one multiply per set
// bit; a stalled result holds the item in the done state until it is taken.
// Synchronous reset restores the register defaults and idles the sequencer.
// req_stall stays high from acceptance until the result word is taken.
`timescale 1ns / 1ps
`default_nettype none
module rsa_modular_exponentiation_top #(
   parameter int DATA_WIDTH = rsamx_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_cmd,
   input  wire logic [rsamx_pkg::FIELD_WIDTH-1:0]     req_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [rsamx_pkg::FIELD_WIDTH-1:0]          rsp_result,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [rsamx_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [rsamx_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [rsamx_pkg::CSR_DATA_WIDTH-1:0]       prdata,
   output logic                                       pready
);

   localparam int FW = rsamx_pkg::FIELD_WIDTH;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RED  = 3'd1;
   localparam logic [2:0] ST_EXP  = 3'd2;
   localparam logic [2:0] ST_MULA = 3'd3;
   localparam logic [2:0] ST_SQR  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [FW-1:0] modulus_ff, pub_exp_ff, priv_exp_ff;
   logic [1:0]    reg_index;
   logic          csr_write;

   logic [2:0]            state_ff, state_in;
   logic                  cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0] exp_ff, exp_in;
   logic [DATA_WIDTH-1:0] base_ff, base_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [FW-1:0]         result_ff, result_in;

   logic [DATA_WIDTH-1:0] mod_w, pub_w, priv_w, value_w;
   logic [FW-1:0]         acc_field;

   logic                  mul_start, mul_done;
   logic [DATA_WIDTH-1:0] mul_a, mul_b, mul_product;

   // configuration registers
   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= rsamx_pkg::RESET_MODULUS;
         pub_exp_ff  <= rsamx_pkg::RESET_PUB_EXP;
         priv_exp_ff <= rsamx_pkg::RESET_PRIV_EXP;
      end else if (csr_write) begin
         case (reg_index)
            rsamx_pkg::REG_MODULUS:  modulus_ff  <= pwdata[FW-1:0];
            rsamx_pkg::REG_PUB_EXP:  pub_exp_ff  <= pwdata[FW-1:0];
            rsamx_pkg::REG_PRIV_EXP: priv_exp_ff <= pwdata[FW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         rsamx_pkg::REG_MODULUS:  prdata = rsamx_pkg::CSR_DATA_WIDTH'(modulus_ff);
         rsamx_pkg::REG_PUB_EXP:  prdata = rsamx_pkg::CSR_DATA_WIDTH'(pub_exp_ff);
         rsamx_pkg::REG_PRIV_EXP: prdata = rsamx_pkg::CSR_DATA_WIDTH'(priv_exp_ff);
         default:                 prdata = '0;
      endcase
   end

   // fit the 16-bit fields to the datapath width
   always_comb begin
      logic [63:0] mod_x, pub_x, priv_x, val_x, acc_x;
      mod_x     = 64'(modulus_ff);
      pub_x     = 64'(pub_exp_ff);
      priv_x    = 64'(priv_exp_ff);
      val_x     = 64'(req_value);
      acc_x     = 64'(acc_ff);
      mod_w     = mod_x[DATA_WIDTH-1:0];
      pub_w     = pub_x[DATA_WIDTH-1:0];
      priv_w    = priv_x[DATA_WIDTH-1:0];
      value_w   = val_x[DATA_WIDTH-1:0];
      acc_field = acc_x[FW-1:0];
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      exp_in    = exp_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      result_in = result_ff;
      mul_start = 1'b0;
      mul_a     = acc_ff;
      mul_b     = base_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               exp_in = (req_cmd == rsamx_pkg::CMD_DECRYPT) ? priv_w : pub_w;
               if (mod_w < DATA_WIDTH'(2)) begin
                  result_in = '0;
                  state_in  = ST_DONE;
               end else begin
                  // base mod m as 1 * base through the multiplier
                  mul_start = 1'b1;
                  mul_a     = DATA_WIDTH'(1);
                  mul_b     = value_w;
                  state_in  = ST_RED;
               end
            end
         end
         ST_RED: begin
            if (mul_done) begin
               base_in  = mul_product;
               acc_in   = DATA_WIDTH'(1);
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            if (exp_ff == '0) begin
               result_in = (cmd_ff == rsamx_pkg::CMD_DECRYPT)
                           ? {{(FW-8){1'b0}}, acc_field[7:0]} : acc_field;
               state_in  = ST_DONE;
            end else if (exp_ff[0]) begin
               mul_start = 1'b1;
               mul_a     = acc_ff;
               mul_b     = base_ff;
               state_in  = ST_MULA;
            end else begin
               mul_start = 1'b1;
               mul_a     = base_ff;
               mul_b     = base_ff;
               state_in  = ST_SQR;
            end
         end
         ST_MULA: begin
            if (mul_done) begin
               acc_in    = mul_product;
               mul_start = 1'b1;
               mul_a     = base_ff;
               mul_b     = base_ff;
               state_in  = ST_SQR;
            end
         end
         ST_SQR: begin
            if (mul_done) begin
               base_in  = mul_product;
               exp_in   = exp_ff >> 1;
               state_in = ST_EXP;
            end
         end
         ST_DONE: begin
            // hold the word until the receiver takes it
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff    <= cmd_in;
      exp_ff    <= exp_in;
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   rsamx_modmul #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (mod_w),
      .done    (mul_done),
      .product (mul_product)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_DONE);
   assign rsp_result = result_ff;

endmodule
`default_nettype wire

// File: tb/tb_rsa_modular_exponentiation_top.sv
// Self-checking testbench for the RSA modular exponentiation block.
`timescale 1ns / 1ps
module tb_rsa_modular_exponentiation_top;

   typedef logic [rsamx_pkg::FIELD_WIDTH-1:0] field_type;
   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;
   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   reg_idx;
      field_type    reg_data;
      logic         cmd;
      field_type    value;
      logic         known;
      field_type    result;
   } plan_row_type;

   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam logic LIT  = 1'b1;
   localparam logic CALC = 1'b0;

   localparam int NUM_DIRECTED    = 32;
   localparam int NUM_PHASES      = 12;
   localparam int WORDS_PER_PHASE = 98;
   localparam int CALM_PHASE      = 2;
   localparam int HOLD_PHASE      = 5;
   localparam int HOLD_CYCLES     = 3000;
   localparam int TAIL_CYCLES     = 1300;
   localparam int WATCHDOG_LIMIT  = 20000;

   // Directed sequence: literal results only where they follow at a glance.
   localparam plan_row_type DIRECTED_PLAN [NUM_DIRECTED] = '{
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd0, LIT, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd1, LIT, 16'd1},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd2, LIT, 16'd128},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd65535, CALC, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_DECRYPT, 16'd0, LIT, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_DECRYPT, 16'd1, LIT, 16'd1},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_DECRYPT, 16'd65535, CALC, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd5141, LIT, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd5142, LIT, 16'd1},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_DECRYPT, 16'd5140, CALC, 16'd0},
      '{ROW_CSR, rsamx_pkg::REG_PUB_EXP, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd0, CALC, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd12345, LIT, 16'd1},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd0, LIT, 16'd1},
      '{ROW_CSR, rsamx_pkg::REG_PRIV_EXP, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd0, CALC, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_DECRYPT, 16'd999, LIT, 16'd1},
      '{ROW_CSR, rsamx_pkg::REG_MODULUS, 16'd1, rsamx_pkg::CMD_ENCRYPT, 16'd0, CALC, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd7, LIT, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_DECRYPT, 16'd0, LIT, 16'd0},
      '{ROW_CSR, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd0, CALC, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd65535, LIT, 16'd0},
      '{ROW_CSR, rsamx_pkg::REG_MODULUS, 16'd65535, rsamx_pkg::CMD_ENCRYPT, 16'd0, CALC, 16'd0},
      '{ROW_CSR, rsamx_pkg::REG_PUB_EXP, 16'd65535, rsamx_pkg::CMD_ENCRYPT, 16'd0, CALC, 16'd0},
      '{ROW_CSR, rsamx_pkg::REG_PRIV_EXP, 16'd65535, rsamx_pkg::CMD_ENCRYPT, 16'd0, CALC, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd65534, CALC, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_DECRYPT, 16'd65535, LIT, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd2, CALC, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_DECRYPT, 16'd12345, CALC, 16'd0},
      '{ROW_CSR, REG_SPARE, 16'h1234, rsamx_pkg::CMD_ENCRYPT, 16'd0, CALC, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd3, CALC, 16'd0},
      '{ROW_CSR, rsamx_pkg::REG_MODULUS, 16'd2, rsamx_pkg::CMD_ENCRYPT, 16'd0, CALC, 16'd0},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_ENCRYPT, 16'd65535, LIT, 16'd1},
      '{ROW_WORD, rsamx_pkg::REG_MODULUS, 16'd0, rsamx_pkg::CMD_DECRYPT, 16'd65534, LIT, 16'd0}
   };

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_cmd;
   field_type req_value;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   field_type rsp_result;
   logic psel;
   logic penable;
   logic pwrite;
   logic [rsamx_pkg::CSR_ADDR_WIDTH-1:0] paddr;
   logic [rsamx_pkg::CSR_DATA_WIDTH-1:0] pwdata;
   logic [rsamx_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   field_type modulus_now  = rsamx_pkg::RESET_MODULUS;
   field_type pub_exp_now  = rsamx_pkg::RESET_PUB_EXP;
   field_type priv_exp_now = rsamx_pkg::RESET_PRIV_EXP;

   field_type results_due [$];
   field_type oldest_result;
   int mismatches = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   bit hold_wanted = 1'b0;
   bit hold_served = 1'b0;
   bit calm = 1'b0;

   rsa_modular_exponentiation_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // value ^ exponent mod modulus; decrypt keeps only the character byte
   function automatic field_type predict_power(input logic cmd, input field_type base);
      logic [31:0] m;
      logic [31:0] b;
      logic [31:0] acc;
      field_type e;
      m = modulus_now;
      e = (cmd == rsamx_pkg::CMD_DECRYPT) ? priv_exp_now : pub_exp_now;
      if (m < 2)
         return '0;
      b = base % m;
      acc = 1;
      while (e != 0) begin
         if (e[0])
            acc = (acc * b) % m;
         b = (b * b) % m;
         e = e >> 1;
      end
      if (cmd == rsamx_pkg::CMD_DECRYPT)
         acc = acc & 32'hFF;
      return acc[rsamx_pkg::FIELD_WIDTH-1:0];
   endfunction

   function automatic field_type pick_modulus();
      case ($urandom_range(9))
         0: return field_type'($urandom_range(1));
         1: return 16'd65535;
         2, 3: return field_type'($urandom_range(2, 300));
         default: return field_type'($urandom_range(2, 65535));
      endcase
   endfunction

   function automatic field_type pick_exponent();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'd65535;
         2, 3: return field_type'($urandom_range(1, 15));
         default: return field_type'($urandom_range(65535));
      endcase
   endfunction

   function automatic field_type pick_base();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'd1;
         2: return modulus_now - 16'd1;
         3, 4: return (modulus_now > 1) ? field_type'($urandom_range(modulus_now - 1))
                                        : field_type'($urandom_range(65535));
         default: return field_type'($urandom_range(65535));
      endcase
   endfunction

   task automatic offer_word(input logic cmd, input field_type value, input logic known,
                             input field_type literal);
      while (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      results_due = {results_due, known ? literal : predict_power(cmd, value)};
   endtask

   // drop valid and wait until every outstanding word has come back
   task automatic settle_block();
      req_valid <= 1'b0;
      while (results_due.size() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input field_type data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'($urandom), data};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         rsamx_pkg::REG_MODULUS:  modulus_now  = data;
         rsamx_pkg::REG_PUB_EXP:  pub_exp_now  = data;
         rsamx_pkg::REG_PRIV_EXP: priv_exp_now = data;
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // result side: random stalls, plus one long hold-off to back up the input
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_wanted && !hold_served) begin
         hold_served = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 12);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            $error("rsp_result: expected no word, actual %0d", rsp_result);
            mismatches++;
         end else begin
            oldest_result = results_due.pop_front();
            if (rsp_result !== oldest_result) begin
               $error("rsp_result: expected %0d, actual %0d", oldest_result, rsp_result);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_cmd   <= rsamx_pkg::CMD_ENCRYPT;
      req_value <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_PLAN[i]) begin
         if (DIRECTED_PLAN[i].kind == ROW_CSR) begin
            settle_block();
            write_register(DIRECTED_PLAN[i].reg_idx, DIRECTED_PLAN[i].reg_data);
         end else begin
            offer_word(DIRECTED_PLAN[i].cmd, DIRECTED_PLAN[i].value,
                       DIRECTED_PLAN[i].known, DIRECTED_PLAN[i].result);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         settle_block();
         calm = (phase == CALM_PHASE);
         write_register(rsamx_pkg::REG_MODULUS, pick_modulus());
         write_register(rsamx_pkg::REG_PUB_EXP, pick_exponent());
         write_register(rsamx_pkg::REG_PRIV_EXP, pick_exponent());
         if ($urandom_range(2) == 0)
            write_register(REG_SPARE, field_type'($urandom));
         if (phase == HOLD_PHASE)
            hold_wanted = 1'b1;
         for (int n = 0; n < WORDS_PER_PHASE; n++)
            offer_word(logic'($urandom_range(1)), pick_base(), CALC, '0);
      end

      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
